/* hdl/ppgagc_pkg.sv */
// Shared types and constants for the LED amplitude gain loop.
package ppgagc_pkg;

	localparam int SAMPLE_W   = 18;
	localparam int THR_W      = 18;
	localparam int DRIVE_W    = 8;
	localparam int ITER_W     = 6;
	localparam int STAB_W     = 4;
	localparam int PHASE_W    = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;
	// compare width: wide enough for both operands plus a borrow bit
	localparam int CMP_W      = ((SAMPLE_W > THR_W) ? SAMPLE_W : THR_W) + 1;

	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
	localparam logic [PHASE_W-1:0] PH_WAIT = 2'd1;
	localparam logic [PHASE_W-1:0] PH_CAL  = 2'd2;
	localparam logic [PHASE_W-1:0] PH_DONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FINGER_LEVEL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION_LEVEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_DRIVE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_NEEDED    = 3'd6;

	localparam logic [THR_W-1:0]   RST_FINGER_LEVEL     = 18'd30000;
	localparam logic [THR_W-1:0]   RST_WINDOW_LOW       = 18'd104857;
	localparam logic [THR_W-1:0]   RST_WINDOW_HIGH      = 18'd157285;
	localparam logic [THR_W-1:0]   RST_SATURATION_LEVEL = 18'd235928;
	localparam logic [DRIVE_W-1:0] RST_START_DRIVE      = 8'd110;
	localparam logic [ITER_W-1:0]  RST_ITERATION_LIMIT  = 6'd60;
	localparam logic [STAB_W-1:0]  RST_STABLE_NEEDED    = 4'd3;

	localparam logic [CMP_W-1:0] STEP_GAP = CMP_W'(30000);

	typedef struct packed {
		logic [THR_W-1:0]   finger_level;
		logic [THR_W-1:0]   window_low;
		logic [THR_W-1:0]   window_high;
		logic [THR_W-1:0]   saturation_level;
		logic [DRIVE_W-1:0] start_drive;
		logic [ITER_W-1:0]  iteration_limit;
		logic [STAB_W-1:0]  stable_needed;
	} cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [DRIVE_W-1:0] red_level;
		logic [DRIVE_W-1:0] ir_level;
		logic [ITER_W-1:0]  tick_count;
		logic [STAB_W-1:0]  stable_run;
		logic               ended_stable;
	} loop_state_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] red_drive;
		logic [DRIVE_W-1:0] ir_drive;
		logic               drive_updated;
		logic [PHASE_W-1:0] loop_phase;
		logic               flush_request;
		logic               converged;
	} result_t;

endpackage

/* hdl/ppgagc_cfg.sv */
// Configuration register file for the gain loop.
module ppgagc_cfg
	import ppgagc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.finger_level     <= RST_FINGER_LEVEL;
			cfg_q.window_low       <= RST_WINDOW_LOW;
			cfg_q.window_high      <= RST_WINDOW_HIGH;
			cfg_q.saturation_level <= RST_SATURATION_LEVEL;
			cfg_q.start_drive      <= RST_START_DRIVE;
			cfg_q.iteration_limit  <= RST_ITERATION_LIMIT;
			cfg_q.stable_needed    <= RST_STABLE_NEEDED;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FINGER_LEVEL:     cfg_q.finger_level     <= cfg_data[THR_W-1:0];
				REG_WINDOW_LOW:       cfg_q.window_low       <= cfg_data[THR_W-1:0];
				REG_WINDOW_HIGH:      cfg_q.window_high      <= cfg_data[THR_W-1:0];
				REG_SATURATION_LEVEL: cfg_q.saturation_level <= cfg_data[THR_W-1:0];
				REG_START_DRIVE:      cfg_q.start_drive      <= cfg_data[DRIVE_W-1:0];
				REG_ITERATION_LIMIT:  cfg_q.iteration_limit  <= cfg_data[ITER_W-1:0];
				REG_STABLE_NEEDED:    cfg_q.stable_needed    <= cfg_data[STAB_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* hdl/ppgagc_calc.sv */
// Next-state and result logic for one transaction of the gain loop.
module ppgagc_calc
	import ppgagc_pkg::*;
(
	input  cfg_t                cfg,
	input  loop_state_t         cur,
	input  logic                op,
	input  logic                sample_valid,
	input  logic [SAMPLE_W-1:0] red_sample,
	input  logic [SAMPLE_W-1:0] ir_sample,
	output loop_state_t         nxt,
	output result_t             res
);

	// {changed, new level}
	function automatic logic [DRIVE_W:0] adjust_level(
		input logic [DRIVE_W-1:0] lvl,
		input logic [CMP_W-1:0]   s,
		input logic [CMP_W-1:0]   sat,
		input logic [CMP_W-1:0]   wh,
		input logic [CMP_W-1:0]   wl
	);
		logic [CMP_W-1:0]   diff;
		logic [DRIVE_W-1:0] step;
		logic [DRIVE_W:0]   sum;
		logic [DRIVE_W:0]   r;
		r    = {1'b0, lvl};
		diff = '0;
		step = '0;
		sum  = '0;
		if (s > sat && lvl > 8'd5) begin
			r = {1'b1, (lvl > 8'd15) ? lvl - 8'd10 : 8'd1};
		end else if (s > wh && lvl > 8'd1) begin
			diff = s - wh;
			step = (diff > STEP_GAP) ? 8'd3 : 8'd1;
			r    = {1'b1, (lvl > step) ? lvl - step : 8'd1};
		end else if (s < wl && lvl < 8'hFE) begin
			diff = wl - s;
			step = (diff > STEP_GAP) ? 8'd3 : 8'd1;
			sum  = {1'b0, lvl} + {1'b0, step};
			r    = {1'b1, (sum > 9'h0FF) ? 8'hFF : sum[DRIVE_W-1:0]};
		end
		return r;
	endfunction

	logic [CMP_W-1:0]   red_x, ir_x, fl_x, wl_x, wh_x, sat_x;
	logic [DRIVE_W:0]   red_adj, ir_adj;
	logic [STAB_W-1:0]  stable_inc;
	logic [ITER_W-1:0]  tick_inc;
	logic [DRIVE_W-1:0] load_drive;
	logic               red_ok, ir_ok, finger_seen, conv, changed, flush;

	assign red_x = CMP_W'(red_sample);
	assign ir_x  = CMP_W'(ir_sample);
	assign fl_x  = CMP_W'(cfg.finger_level);
	assign wl_x  = CMP_W'(cfg.window_low);
	assign wh_x  = CMP_W'(cfg.window_high);
	assign sat_x = CMP_W'(cfg.saturation_level);

	assign red_adj     = adjust_level(cur.red_level, red_x, sat_x, wh_x, wl_x);
	assign ir_adj      = adjust_level(cur.ir_level, ir_x, sat_x, wh_x, wl_x);
	assign red_ok      = (red_x >= wl_x) && (red_x <= wh_x);
	assign ir_ok       = (ir_x >= wl_x) && (ir_x <= wh_x);
	assign finger_seen = (red_x >= fl_x) || (ir_x >= fl_x);
	assign stable_inc  = (cur.stable_run != '1) ? cur.stable_run + 1'b1 : cur.stable_run;
	assign tick_inc    = (cur.tick_count != '1) ? cur.tick_count + 1'b1 : cur.tick_count;
	assign load_drive  = (cfg.start_drive == '0) ? 8'd1 : cfg.start_drive;

	always_comb begin
		nxt     = cur;
		changed = 1'b0;
		flush   = 1'b0;
		conv    = 1'b0;
		if (op == OP_START) begin
			nxt.red_level    = load_drive;
			nxt.ir_level     = load_drive;
			nxt.phase        = PH_WAIT;
			nxt.tick_count   = '0;
			nxt.stable_run   = '0;
			nxt.ended_stable = 1'b0;
			changed          = 1'b1;
			flush            = 1'b1;
		end else if (cur.phase == PH_WAIT) begin
			if (sample_valid && finger_seen) begin
				nxt.phase      = PH_CAL;
				nxt.tick_count = '0;
				nxt.stable_run = '0;
				flush          = 1'b1;
			end
		end else if (cur.phase == PH_CAL) begin
			nxt.tick_count = tick_inc;
			if (sample_valid) begin
				if (!finger_seen) begin
					nxt.stable_run = '0;
				end else begin
					if (red_ok && ir_ok) begin
						nxt.stable_run = stable_inc;
						conv = (stable_inc >= cfg.stable_needed);
					end else begin
						nxt.stable_run = '0;
					end
					if (!conv) begin
						nxt.red_level = red_adj[DRIVE_W-1:0];
						nxt.ir_level  = ir_adj[DRIVE_W-1:0];
						changed       = red_adj[DRIVE_W] | ir_adj[DRIVE_W];
					end
				end
			end
			if (conv) begin
				nxt.phase        = PH_DONE;
				nxt.ended_stable = 1'b1;
				flush            = 1'b1;
			end else if (tick_inc >= cfg.iteration_limit) begin
				nxt.phase        = PH_DONE;
				nxt.ended_stable = 1'b0;
				flush            = 1'b1;
			end
		end
	end

	assign res.red_drive     = nxt.red_level;
	assign res.ir_drive      = nxt.ir_level;
	assign res.drive_updated = changed;
	assign res.loop_phase    = nxt.phase;
	assign res.flush_request = flush;
	assign res.converged     = nxt.ended_stable;

endmodule

/* hdl/ppg_led_amplitude_agc.sv */
// Top level of the two-LED drive gain loop: input stage, loop state and result register.
// An item is registered in the input stage, then in the result register, which offers its result.
// Throughput: one transaction per cycle unless the result side stalls; the loop state updates
//   as an item leaves the input stage, so the next item in the input stage already sees it.
// Reset (arst_n low, asynchronous): phase idle, drive levels and counters zero, config
//   registers at their defaults, both stages empty. Config writes are never stalled.
module ppg_led_amplitude_agc
	import ppgagc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// item channel
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  op,
	input  logic                  sample_valid,
	input  logic [SAMPLE_W-1:0]   red_sample,
	input  logic [SAMPLE_W-1:0]   ir_sample,
	// result channel
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [DRIVE_W-1:0]    red_drive,
	output logic [DRIVE_W-1:0]    ir_drive,
	output logic                  drive_updated,
	output logic [PHASE_W-1:0]    loop_phase,
	output logic                  flush_request,
	output logic                  converged,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                cfg;
	loop_state_t         state_q, state_nxt;
	result_t             res_q, res_nxt;

	// input stage
	logic                s1_valid_q;
	logic                op_s1, sample_valid_s1;
	logic [SAMPLE_W-1:0] red_s1, ir_s1;

	logic                res_valid_q;
	logic                res_free;   // result register can take a new transaction
	logic                s1_fire;    // input stage hands its item to the result register
	logic                in_fire;

	ppgagc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ppgagc_calc u_calc (
		.cfg          (cfg),
		.cur          (state_q),
		.op           (op_s1),
		.sample_valid (sample_valid_s1),
		.red_sample   (red_s1),
		.ir_sample    (ir_s1),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	// Result register frees up when empty or when its transaction is taken this cycle.
	assign res_free   = !res_valid_q || !res_stall;
	assign s1_fire    = s1_valid_q && res_free;
	// Input stage is blocked only when it is full and cannot move on.
	assign item_stall = s1_valid_q && !res_free;
	assign in_fire    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1           <= op;
			sample_valid_s1 <= sample_valid;
			red_s1          <= red_sample;
			ir_s1           <= ir_sample;
		end
	end

	// Loop state advances exactly once per transaction, as it enters the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_IDLE;
			state_q.red_level    <= '0;
			state_q.ir_level     <= '0;
			state_q.tick_count   <= '0;
			state_q.stable_run   <= '0;
			state_q.ended_stable <= 1'b0;
		end else if (s1_fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= s1_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid     = res_valid_q;
	assign red_drive     = res_q.red_drive;
	assign ir_drive      = res_q.ir_drive;
	assign drive_updated = res_q.drive_updated;
	assign loop_phase    = res_q.loop_phase;
	assign flush_request = res_q.flush_request;
	assign converged     = res_q.converged;

	// Once a start has been seen, drive levels never fall to zero.
	a_levels_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase != PH_IDLE) |-> (state_q.red_level != '0 && state_q.ir_level != '0))
		else $error("drive level zero outside idle");

	// Stability flag only exists in the finished phase.
	a_conv_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.ended_stable |-> (state_q.phase == PH_DONE))
		else $error("ended_stable set outside finished phase");

	// Drive change while waiting can only come from a start, which always flushes.
	a_wait_update_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.drive_updated && res_q.loop_phase == PH_WAIT)
			|-> res_q.flush_request)
		else $error("drive update in wait phase without flush");

	// Loop state holds while no transaction moves through.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_fire |=> $stable(state_q))
		else $error("loop state changed without a transaction");

	// Input back-pressure only when both stages are occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (s1_valid_q && res_valid_q))
		else $error("input stalled with a free stage");

endmodule

/* tb/agc_drive_tracker_pkg.sv */
// Scoreboard class for the LED drive gain loop: predicts each result and checks it.
package agc_drive_tracker_pkg;
	import ppgagc_pkg::*;

	class agc_drive_tracker;
		logic [THR_W-1:0]   finger_lvl;
		logic [THR_W-1:0]   win_lo;
		logic [THR_W-1:0]   win_hi;
		logic [THR_W-1:0]   sat_lvl;
		logic [DRIVE_W-1:0] start_lvl;
		logic [ITER_W-1:0]  iter_lim;
		logic [STAB_W-1:0]  stab_need;
		loop_state_t        st;
		result_t            awaited[$];
		int unsigned        faults;
		int unsigned        seen;

		function new();
			finger_lvl = RST_FINGER_LEVEL;
			win_lo     = RST_WINDOW_LOW;
			win_hi     = RST_WINDOW_HIGH;
			sat_lvl    = RST_SATURATION_LEVEL;
			start_lvl  = RST_START_DRIVE;
			iter_lim   = RST_ITERATION_LIMIT;
			stab_need  = RST_STABLE_NEEDED;
			st         = '0;
			st.phase   = PH_IDLE;
			faults     = 0;
			seen       = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FINGER_LEVEL:     finger_lvl = data[THR_W-1:0];
				REG_WINDOW_LOW:       win_lo     = data[THR_W-1:0];
				REG_WINDOW_HIGH:      win_hi     = data[THR_W-1:0];
				REG_SATURATION_LEVEL: sat_lvl    = data[THR_W-1:0];
				REG_START_DRIVE:      start_lvl  = data[DRIVE_W-1:0];
				REG_ITERATION_LIMIT:  iter_lim   = data[ITER_W-1:0];
				REG_STABLE_NEEDED:    stab_need  = data[STAB_W-1:0];
				default: ;
			endcase
		endfunction

		// coarse step on saturation, else 1 or 3 toward the window
		function logic [DRIVE_W-1:0] nudge(logic [DRIVE_W-1:0] lvl, logic [SAMPLE_W-1:0] s,
				inout bit moved);
			int unsigned lv;
			int unsigned sv;
			int unsigned step;
			lv = lvl;
			sv = s;
			if (sv > sat_lvl && lv > 5) begin
				lv = (lv > 15) ? lv - 10 : 1;
				moved = 1'b1;
			end else if (sv > win_hi && lv > 1) begin
				step = (sv - win_hi > STEP_GAP) ? 3 : 1;
				lv = (lv > step) ? lv - step : 1;
				moved = 1'b1;
			end else if (sv < win_lo && lv < 254) begin
				step = (win_lo - sv > STEP_GAP) ? 3 : 1;
				lv = (lv + step > 255) ? 255 : lv + step;
				moved = 1'b1;
			end
			return DRIVE_W'(lv);
		endfunction

		function void note_item(logic o, logic v, logic [SAMPLE_W-1:0] r, logic [SAMPLE_W-1:0] i);
			result_t            want;
			logic [DRIVE_W-1:0] lvl;
			bit                 moved;
			bit                 flush;
			bit                 conv;
			moved = 1'b0;
			flush = 1'b0;
			conv  = 1'b0;
			if (o == OP_START) begin
				lvl = (start_lvl == '0) ? DRIVE_W'(1) : start_lvl;
				st.red_level    = lvl;
				st.ir_level     = lvl;
				st.phase        = PH_WAIT;
				st.tick_count   = '0;
				st.stable_run   = '0;
				st.ended_stable = 1'b0;
				moved = 1'b1;
				flush = 1'b1;
			end else if (st.phase == PH_WAIT) begin
				if (v && (i >= finger_lvl || r >= finger_lvl)) begin
					st.phase      = PH_CAL;
					st.tick_count = '0;
					st.stable_run = '0;
					flush = 1'b1;
				end
			end else if (st.phase == PH_CAL) begin
				if (st.tick_count < 63)
					st.tick_count++;
				if (v) begin
					if (i < finger_lvl && r < finger_lvl) begin
						st.stable_run = '0;
					end else begin
						if (r >= win_lo && r <= win_hi && i >= win_lo && i <= win_hi) begin
							if (st.stable_run < 15)
								st.stable_run++;
							conv = (st.stable_run >= stab_need);
						end else begin
							st.stable_run = '0;
						end
						if (!conv) begin
							st.red_level = nudge(st.red_level, r, moved);
							st.ir_level  = nudge(st.ir_level, i, moved);
						end
					end
				end
				if (conv) begin
					st.phase        = PH_DONE;
					st.ended_stable = 1'b1;
					flush = 1'b1;
				end else if (st.tick_count >= iter_lim) begin
					st.phase        = PH_DONE;
					st.ended_stable = 1'b0;
					flush = 1'b1;
				end
			end
			want.red_drive     = st.red_level;
			want.ir_drive      = st.ir_level;
			want.drive_updated = moved;
			want.loop_phase    = st.phase;
			want.flush_request = flush;
			want.converged     = st.ended_stable;
			awaited.push_back(want);
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			faults++;
		endtask

		task check_field(string name, logic [DRIVE_W-1:0] got, logic [DRIVE_W-1:0] want);
			if (got !== want)
				report($sformatf("result %0d %s got %0d expected %0d", seen, name, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result %0d arrived with none awaited (drives %0d/%0d)",
					seen, got.red_drive, got.ir_drive));
			end else begin
				want = awaited.pop_front();
				check_field("red_drive", got.red_drive, want.red_drive);
				check_field("ir_drive", got.ir_drive, want.ir_drive);
				check_field("drive_updated", DRIVE_W'(got.drive_updated), DRIVE_W'(want.drive_updated));
				check_field("loop_phase", DRIVE_W'(got.loop_phase), DRIVE_W'(want.loop_phase));
				check_field("flush_request", DRIVE_W'(got.flush_request), DRIVE_W'(want.flush_request));
				check_field("converged", DRIVE_W'(got.converged), DRIVE_W'(want.converged));
			end
			seen++;
		endtask

		task close();
			if (awaited.size() != 0)
				report($sformatf("%0d expected results never arrived", awaited.size()));
			awaited.delete();
		endtask
	endclass

endpackage

/* tb/ppg_led_amplitude_agc_test.sv */
// Self-checking bench for the two-LED drive gain loop: sessions, config sweeps, stalls.
module ppg_led_amplitude_agc_test;
	import ppgagc_pkg::*;
	import agc_drive_tracker_pkg::*;

	localparam int unsigned FULL = (1 << SAMPLE_W) - 1;
	localparam int QUIET_LIMIT   = 4000;   // cycles with no transaction on any channel
	localparam int HOLD_CYCLES   = 90;     // long receiver hold-off
	localparam int PHASES        = 9;
	localparam int PHASE_ITEMS   = 155;    // live items per config phase, ~1400 overall
	localparam int SETTLE_CYCLES = 6;      // waited after the last result before touching config
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum int unsigned {
		S_WINDOW, S_SATURATED, S_ABOVE, S_BELOW, S_ABSENT, S_ANY, S_EDGE
	} sample_kind_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	logic                  op           = OP_TICK;
	logic                  sample_valid = 1'b0;
	logic [SAMPLE_W-1:0]   red_sample   = '0;
	logic [SAMPLE_W-1:0]   ir_sample    = '0;
	logic                  res_valid;
	logic                  res_stall    = 1'b0;
	logic [DRIVE_W-1:0]    red_drive;
	logic [DRIVE_W-1:0]    ir_drive;
	logic                  drive_updated;
	logic [PHASE_W-1:0]    loop_phase;
	logic                  flush_request;
	logic                  converged;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = REG_FINGER_LEVEL;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	agc_drive_tracker sb = new();

	// pacing state; the hold-off variables are shared between sender and receiver
	bit hold_req   = 1'b0;
	int hold_left  = 0;
	int calm_left  = 0;
	int live_items = 0;

	ppg_led_amplitude_agc dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.op            (op),
		.sample_valid  (sample_valid),
		.red_sample    (red_sample),
		.ir_sample     (ir_sample),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.red_drive     (red_drive),
		.ir_drive      (ir_drive),
		.drive_updated (drive_updated),
		.loop_phase    (loop_phase),
		.flush_request (flush_request),
		.converged     (converged),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- stimulus helpers

	// sender gap: mostly none or short, now and then long; none during a hold-off
	// so the block backs up, and none through calm stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (hold_req || hold_left > 0)
			return 0;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if (r < 3) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// sample drawn relative to the thresholds currently programmed
	function automatic logic [SAMPLE_W-1:0] pick_sample(input sample_kind_t k);
		int unsigned lo;
		int unsigned hi;
		int unsigned sat;
		int unsigned fl;
		int unsigned v;
		lo  = sb.win_lo;
		hi  = sb.win_hi;
		sat = sb.sat_lvl;
		fl  = sb.finger_lvl;
		case (k)
			S_WINDOW:    v = $urandom_range(lo, hi);
			S_SATURATED: v = (sat >= FULL) ? FULL : $urandom_range(sat + 1, FULL);
			S_ABOVE:     v = $urandom_range((hi >= FULL) ? FULL : hi + 1, sat);
			S_BELOW:     v = (lo == 0) ? 0 : $urandom_range(0, lo - 1);
			S_ABSENT:    v = (fl == 0) ? 0 : $urandom_range(0, fl - 1);
			S_EDGE: begin
				case ($urandom_range(0, 7))
					0: v = 0;
					1: v = FULL;
					2: v = lo;
					3: v = hi;
					4: v = fl;
					5: v = sat;
					6: v = lo - 1;
					default: v = hi + 1;
				endcase
			end
			default:     v = $urandom;
		endcase
		return SAMPLE_W'(v);
	endfunction

	function automatic sample_kind_t any_kind();
		return sample_kind_t'($urandom_range(0, S_EDGE));
	endfunction

	// narrow registers sometimes get junk above their width; only the low bits count
	function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
			input int w);
		logic [CFG_DATA_W-1:0] j;
		j = CFG_DATA_W'($urandom) << w;
		return ($urandom_range(0, 3) == 0) ? (v | j) : v;
	endfunction

	task automatic idle(input int n);
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// one input transaction; valid stays high into the next item unless a gap follows
	task automatic send_item(input logic o, input logic v, input logic [SAMPLE_W-1:0] r,
			input logic [SAMPLE_W-1:0] i);
		if (o == OP_START || sb.st.phase == PH_WAIT || sb.st.phase == PH_CAL)
			live_items++;
		item_valid   <= 1'b1;
		op           <= o;
		sample_valid <= v;
		red_sample   <= r;
		ir_sample    <= i;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(o, v, r, i);
		idle(pick_gap());
	endtask

	task automatic write_reg_tx(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// drain: every item yields a result, so an empty queue plus latency means idle
	task automatic settle();
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- stimulus

	// reset config; walks the loop through every phase and step rule by hand
	task automatic directed();
		send_item(OP_TICK, 1'b0, '0, '0);                          // idle tick
		send_item(OP_TICK, 1'b1, SAMPLE_W'(FULL), SAMPLE_W'(FULL)); // idle, ignored
		send_item(OP_START, 1'b0, '0, '0);
		send_item(OP_TICK, 1'b0, SAMPLE_W'(FULL), SAMPLE_W'(FULL)); // waiting, no sample
		send_item(OP_TICK, 1'b1, SAMPLE_W'(RST_FINGER_LEVEL - 1), SAMPLE_W'(RST_FINGER_LEVEL - 1));
		send_item(OP_TICK, 1'b1, SAMPLE_W'(RST_FINGER_LEVEL), '0);  // red exactly at level
		send_item(OP_TICK, 1'b0, '0, '0);                          // iteration only
		send_item(OP_TICK, 1'b1, SAMPLE_W'(FULL), SAMPLE_W'(FULL)); // coarse step down
		send_item(OP_TICK, 1'b1, '0, '0);                          // finger removed
		send_item(OP_TICK, 1'b1, SAMPLE_W'(RST_WINDOW_HIGH + 40000),
			SAMPLE_W'(RST_WINDOW_HIGH + 1));                        // down by 3 and by 1
		send_item(OP_TICK, 1'b1, SAMPLE_W'(RST_FINGER_LEVEL),
			SAMPLE_W'(RST_WINDOW_LOW - 1));                         // up by 3 and by 1
		send_item(OP_TICK, 1'b1, SAMPLE_W'(RST_WINDOW_LOW), SAMPLE_W'(RST_WINDOW_HIGH));
		send_item(OP_TICK, 1'b1, SAMPLE_W'(130000), SAMPLE_W'(130000));
		send_item(OP_TICK, 1'b1, SAMPLE_W'(RST_WINDOW_HIGH), SAMPLE_W'(RST_WINDOW_LOW));
		send_item(OP_TICK, 1'b1, '0, SAMPLE_W'(FULL));              // finished, ignored
		send_item(OP_START, 1'b1, SAMPLE_W'(FULL), SAMPLE_W'(FULL));
		send_item(OP_TICK, 1'b1, '0, SAMPLE_W'(FULL));              // finger on ir only
		send_item(OP_TICK, 1'b1, SAMPLE_W'(120000), SAMPLE_W'(140000));
		send_item(OP_START, 1'b0, '0, '0);                         // restart mid-calibration
		send_item(OP_TICK, 1'b1, SAMPLE_W'(FULL), SAMPLE_W'(1));
	endtask

	// well-formed session: start, a few idle waits, finger, then calibration until done or cut short
	task automatic run_session();
		int                  bias;
		int                  ticks;
		bit                  upward;
		logic                v;
		logic [SAMPLE_W-1:0] hit;
		logic [SAMPLE_W-1:0] other;
		sample_kind_t        kr;
		sample_kind_t        ki;
		send_item(OP_START, 1'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
		repeat ($urandom_range(0, 3)) begin
			if (sb.finger_lvl != '0 && $urandom_range(0, 1) == 1)
				send_item(OP_TICK, 1'b1, pick_sample(S_ABSENT), pick_sample(S_ABSENT));
			else
				send_item(OP_TICK, 1'b0, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
		end
		hit   = SAMPLE_W'($urandom_range(sb.finger_lvl, FULL));
		other = pick_sample(any_kind());
		if ($urandom_range(0, 1) == 1)
			send_item(OP_TICK, 1'b1, hit, other);
		else
			send_item(OP_TICK, 1'b1, other, hit);
		// 0: aim for convergence, 1: anything goes, 2: push levels to a rail
		bias   = $urandom_range(0, 2);
		upward = 1'($urandom);
		ticks  = 0;
		while (sb.st.phase == PH_CAL && ticks < 80) begin
			if ($urandom_range(0, 99) < 2)
				break;
			kr = any_kind();
			ki = any_kind();
			if (bias == 0 && $urandom_range(0, 99) < 85) begin
				kr = S_WINDOW;
				ki = S_WINDOW;
			end else if (bias == 2 && $urandom_range(0, 99) < 90) begin
				kr = upward ? S_BELOW : S_SATURATED;
				ki = kr;
			end
			v = ($urandom_range(0, 99) < 94);
			send_item(OP_TICK, v, pick_sample(kr), pick_sample(ki));
			ticks++;
		end
		repeat ($urandom_range(0, 2))
			send_item(OP_TICK, 1'($urandom), pick_sample(any_kind()), pick_sample(any_kind()));
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(3, 8))
			send_item(($urandom_range(0, 4) == 0) ? OP_START : OP_TICK, 1'($urandom),
				pick_sample(any_kind()), pick_sample(any_kind()));
	endtask

	task automatic run_random(input int k);
		live_items = 0;
		if (k == 3 || k == 6)
			hold_req = 1'b1;
		while (live_items < PHASE_ITEMS) begin
			if ($urandom_range(0, 99) < 8)
				noise_burst();
			else
				run_session();
		end
	endtask

	// one config setting per phase; the first three are the corners, the last restores reset
	task automatic program_phase(input int k);
		cfg_t        c;
		int unsigned lo;
		int unsigned hi;
		int unsigned sat;
		c.finger_level     = RST_FINGER_LEVEL;
		c.window_low       = RST_WINDOW_LOW;
		c.window_high      = RST_WINDOW_HIGH;
		c.saturation_level = RST_SATURATION_LEVEL;
		c.start_drive      = RST_START_DRIVE;
		c.iteration_limit  = RST_ITERATION_LIMIT;
		c.stable_needed    = RST_STABLE_NEEDED;
		case (k)
			0: begin
				c.finger_level     = THR_W'(FULL);
				c.window_low       = '0;
				c.window_high      = THR_W'(FULL);
				c.saturation_level = THR_W'(FULL);
				c.start_drive      = '1;
				c.iteration_limit  = '1;
				c.stable_needed    = '1;
			end
			1: begin
				// zero start drive, zero limits, window upside down
				c.finger_level     = '0;
				c.window_low       = THR_W'(FULL);
				c.window_high      = '0;
				c.saturation_level = '0;
				c.start_drive      = '0;
				c.iteration_limit  = '0;
				c.stable_needed    = '0;
			end
			2: begin
				c.finger_level    = THR_W'($urandom_range(1, 5000));
				c.start_drive     = DRIVE_W'(1);
				c.iteration_limit = ITER_W'(1);
				c.stable_needed   = STAB_W'(1);
			end
			PHASES - 1: ;
			default: begin
				lo  = $urandom_range(40000, 140000);
				hi  = lo + $urandom_range(0, 80000);
				sat = hi + $urandom_range(0, 60000);
				c.finger_level     = THR_W'($urandom_range(1000, 80000));
				c.window_low       = THR_W'(lo);
				c.window_high      = THR_W'((hi > FULL) ? FULL : hi);
				c.saturation_level = THR_W'((sat > FULL) ? FULL : sat);
				c.start_drive      = DRIVE_W'($urandom_range(1, 255));
				c.iteration_limit  = ITER_W'($urandom_range(1, 63));
				c.stable_needed    = STAB_W'($urandom_range(1, 15));
			end
		endcase
		write_reg_tx(REG_FINGER_LEVEL, c.finger_level);
		write_reg_tx(REG_WINDOW_LOW, c.window_low);
		write_reg_tx(REG_WINDOW_HIGH, c.window_high);
		write_reg_tx(REG_SATURATION_LEVEL, c.saturation_level);
		write_reg_tx(REG_START_DRIVE, with_junk(CFG_DATA_W'(c.start_drive), DRIVE_W));
		write_reg_tx(REG_ITERATION_LIMIT, with_junk(CFG_DATA_W'(c.iteration_limit), ITER_W));
		write_reg_tx(REG_STABLE_NEEDED, with_junk(CFG_DATA_W'(c.stable_needed), STAB_W));
		if (k == 3)
			write_reg_tx(REG_UNUSED, CFG_DATA_W'($urandom)); // unmapped index, no effect
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------- result side

	// checks each accepted result, then picks next cycle's stall; a hold-off
	// request turns into one long stall counted here
	initial begin
		result_t got;
		int      run_left;
		bit      stalling;
		bit      nxt;
		run_left = 0;
		stalling = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				got.red_drive     = red_drive;
				got.ir_drive      = ir_drive;
				got.drive_updated = drive_updated;
				got.loop_phase    = loop_phase;
				got.flush_request = flush_request;
				got.converged     = converged;
				sb.check_result(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b1;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				nxt = 1'b1;
			end else begin
				if (run_left == 0) begin
					stalling = ~stalling;
					if (stalling) begin
						case ($urandom_range(0, 19))
							0:       run_left = $urandom_range(20, 40);
							1, 2, 3: run_left = $urandom_range(3, 8);
							default: run_left = $urandom_range(1, 2);
						endcase
					end else begin
						run_left = ($urandom_range(0, 6) == 0) ? 60 : $urandom_range(1, 10);
					end
				end
				run_left--;
				nxt = stalling;
			end
			res_stall <= nxt;
		end
	end

	// ---------------------------------------------------------------- watchdog

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		directed();
		for (int k = 0; k < PHASES; k++) begin
			settle();
			program_phase(k);
			run_random(k);
		end
		settle();
		sb.close();
		if (sb.faults == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* filelist.f */
hdl/ppgagc_pkg.sv
hdl/ppgagc_cfg.sv
hdl/ppgagc_calc.sv
hdl/ppg_led_amplitude_agc.sv
tb/agc_drive_tracker_pkg.sv
tb/ppg_led_amplitude_agc_test.sv
